// ----- rtl/lpfd_pkg.sv -----
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies.
package lpfd_pkg;

    localparam int unsigned HDR_BYTES = 4;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_FRAME = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_BAD_VER   = 2'd3;

    localparam logic [1:0] CFG_MAX_FRAME   = 2'd0;
    localparam logic [1:0] CFG_EXP_VERSION = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

    localparam logic [31:0] MAX_FRAME_RST   = 32'd1048576;
    localparam logic [15:0] EXP_VERSION_RST = 16'd1;
    localparam logic [31:0] MAX_PAYLOAD_RST = 32'd1048572;

    typedef struct packed {
        logic [31:0] max_frame_length;
        logic [15:0] expected_version;
        logic [31:0] max_payload_length;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  status;
        logic [15:0] proto_version;
        logic [15:0] message_type;
        logic [31:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last_of_frame;
    } result_t;

endpackage

// ----- rtl/length_prefixed_frame_deframer.sv -----
// Top level of the length-prefixed frame deframer.
// Depends on lpfd_pkg, lpfd_cfg, lpfd_in_reg, lpfd_core.
//
// Accepts one link byte per clock on the slave stream and keeps that rate
// indefinitely while the master side takes results; each byte passes an
// input register and the parser logic into the result register. The first
// four bytes of a frame form a big-endian length, the next four the version
// and message type; a header result (tuser 0) follows, then one payload word
// per byte (tuser 1) with tlast on the final one. Errors (tuser 2) end the
// frame and the parser waits for a new length. Registers must be written
// by the user on the cfg channel only while no frame is in flight; the
// block does not enforce this.
module length_prefixed_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], proto_version[17:2], message_type[33:18],
    // payload_length[65:34], payload_byte[73:66], zero[79:74]
    output logic [79:0] m_tdata,
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast    // last_of_frame
);

    lpfd_pkg::cfg_t    cfg;
    lpfd_pkg::result_t res;
    logic              byte_valid;
    logic [7:0]        byte_data;
    logic              byte_take;

    assign cfg_ready = 1'b1;

    lpfd_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    lpfd_in_reg u_in
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (byte_valid),
        .out_take  (byte_take),
        .held_data (byte_data)
    );

    lpfd_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (byte_take),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {6'd0, res.payload_byte, res.payload_length,
                      res.message_type, res.proto_version, res.status};
    assign m_tuser = res.result_kind;
    assign m_tlast = res.last_of_frame;

endmodule

// ----- rtl/lpfd_cfg.sv -----
// Configuration register file for the deframer.
// Depends on lpfd_pkg.
module lpfd_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [31:0]        wr_data,
    output lpfd_pkg::cfg_t     cfg
);

    lpfd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_frame_length   <= lpfd_pkg::MAX_FRAME_RST;
            cfg_reg.expected_version   <= lpfd_pkg::EXP_VERSION_RST;
            cfg_reg.max_payload_length <= lpfd_pkg::MAX_PAYLOAD_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                lpfd_pkg::CFG_MAX_FRAME:   cfg_reg.max_frame_length   <= wr_data;
                lpfd_pkg::CFG_EXP_VERSION: cfg_reg.expected_version   <= wr_data[15:0];
                lpfd_pkg::CFG_MAX_PAYLOAD: cfg_reg.max_payload_length <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/lpfd_in_reg.sv -----
// Input word register for the deframer.
// No dependencies.
module lpfd_in_reg
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_data,
    output logic       out_valid,
    input  logic       out_take,
    output logic [7:0] held_data
);

    logic       valid_reg;
    logic [7:0] data_reg;

    assign in_ready = !valid_reg || out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign held_data = data_reg;

endmodule

// ----- rtl/lpfd_core.sv -----
// Frame parser state machine with registered result output.
// Depends on lpfd_pkg.
module lpfd_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  lpfd_pkg::cfg_t      cfg,
    input  logic                byte_valid,
    input  logic [7:0]          byte_data,
    output logic                byte_take,
    output logic                res_valid,
    input  logic                res_ready,
    output lpfd_pkg::result_t   res
);

    localparam logic [1:0] PH_LEN = 2'd0;
    localparam logic [1:0] PH_HDR = 2'd1;
    localparam logic [1:0] PH_PAY = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] hdr_reg, hdr_next;
    logic [31:0] plen_reg, plen_next;
    logic [31:0] rem_reg, rem_next;

    logic              out_valid_reg;
    lpfd_pkg::result_t out_reg;

    logic              emit;
    lpfd_pkg::result_t r;
    logic [31:0]       len_sh;
    logic [31:0]       hdr_sh;
    logic              out_free;

    assign len_sh   = {len_reg[23:0], byte_data};
    assign hdr_sh   = {hdr_reg[23:0], byte_data};
    assign out_free = !out_valid_reg || res_ready;

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        hdr_next   = hdr_reg;
        plen_next  = plen_reg;
        rem_next   = rem_reg;
        emit       = 1'b0;
        r          = '0;
        unique case (phase_reg)
            PH_PAY:
            begin
                emit             = 1'b1;
                r.result_kind    = lpfd_pkg::KIND_PAYLOAD;
                r.status         = lpfd_pkg::ST_OK;
                r.payload_length = plen_reg;
                r.payload_byte   = byte_data;
                r.last_of_frame  = (rem_reg <= 32'd1);
                if (rem_reg != 32'd0)
                begin
                    rem_next = rem_reg - 32'd1;
                end
                if (rem_reg <= 32'd1)
                begin
                    phase_next = PH_LEN;
                    idx_next   = 2'd0;
                end
            end
            PH_HDR:
            begin
                hdr_next = hdr_sh;
                if (idx_reg != 2'd3)
                begin
                    idx_next = idx_reg + 2'd1;
                end
                else
                begin
                    idx_next         = 2'd0;
                    emit             = 1'b1;
                    r.proto_version  = hdr_sh[31:16];
                    r.message_type   = hdr_sh[15:0];
                    r.payload_length = plen_reg;
                    if (hdr_sh[31:16] != cfg.expected_version)
                    begin
                        phase_next      = PH_LEN;
                        r.result_kind   = lpfd_pkg::KIND_ERROR;
                        r.status        = lpfd_pkg::ST_BAD_VER;
                        r.last_of_frame = 1'b1;
                    end
                    else if (plen_reg > cfg.max_payload_length)
                    begin
                        phase_next      = PH_LEN;
                        r.result_kind   = lpfd_pkg::KIND_ERROR;
                        r.status        = lpfd_pkg::ST_TOO_LARGE;
                        r.last_of_frame = 1'b1;
                    end
                    else
                    begin
                        rem_next        = plen_reg;
                        phase_next      = (plen_reg == 32'd0) ? PH_LEN : PH_PAY;
                        r.result_kind   = lpfd_pkg::KIND_HEADER;
                        r.status        = lpfd_pkg::ST_OK;
                        r.last_of_frame = (plen_reg == 32'd0);
                    end
                end
            end
            default:
            begin
                phase_next = PH_LEN;
                len_next   = len_sh;
                if (idx_reg != 2'd3)
                begin
                    idx_next = idx_reg + 2'd1;
                end
                else
                begin
                    idx_next  = 2'd0;
                    plen_next = len_sh - 32'(lpfd_pkg::HDR_BYTES);
                    if (len_sh < 32'(lpfd_pkg::HDR_BYTES))
                    begin
                        emit            = 1'b1;
                        r.result_kind   = lpfd_pkg::KIND_ERROR;
                        r.status        = lpfd_pkg::ST_BAD_FRAME;
                        r.last_of_frame = 1'b1;
                    end
                    else if (len_sh > cfg.max_frame_length)
                    begin
                        emit            = 1'b1;
                        r.result_kind   = lpfd_pkg::KIND_ERROR;
                        r.status        = lpfd_pkg::ST_TOO_LARGE;
                        r.last_of_frame = 1'b1;
                    end
                    else
                    begin
                        hdr_next   = '0;
                        phase_next = PH_HDR;
                    end
                end
            end
        endcase
    end

    // a word that yields no result never waits on the output side
    assign byte_take = byte_valid && (!emit || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEN;
            idx_reg       <= 2'd0;
            len_reg       <= '0;
            hdr_reg       <= '0;
            plen_reg      <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_take)
            begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
                len_reg   <= len_next;
                hdr_reg   <= hdr_next;
                plen_reg  <= plen_next;
                rem_reg   <= rem_next;
            end
            if (out_free)
            begin
                out_valid_reg <= byte_take && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && byte_take && emit)
        begin
            out_reg <= r;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule
